// ----- rtl/hrfp_pkg.sv -----
// Shared constants and types of the HID report frame parser.
package hrfp_pkg;

   // Payload bytes stored between the header and the checksum byte
   localparam int unsigned PAYLOAD_LEN = 8;
   // Byte count wide enough to hold PAYLOAD_LEN itself
   localparam int unsigned COUNT_W = $clog2(PAYLOAD_LEN + 1);

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 8;

   typedef logic [BYTE_W-1:0] byte_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEADER_BYTE   = 3'd0,
      CSR_KEYBOARD_CODE = 3'd1,
      CSR_MOUSE_CODE    = 3'd2,
      CSR_KEYBOARD_EN   = 3'd3,
      CSR_MOUSE_EN      = 3'd4
   } csr_index_type;

   // Input action codes
   localparam logic ACTION_FEED   = 1'b0;
   localparam logic ACTION_RESYNC = 1'b1;

   // Report kind codes
   localparam logic KIND_KEYBOARD = 1'b0;
   localparam logic KIND_MOUSE    = 1'b1;

   // Register reset values
   localparam byte_type HEADER_RESET        = 8'd170;
   localparam byte_type KEYBOARD_CODE_RESET = 8'd1;
   localparam byte_type MOUSE_CODE_RESET    = 8'd2;

endpackage

// ----- rtl/hrfp_cell.sv -----
// One payload byte cell of the shift chain.
module hrfp_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  hrfp_pkg::byte_type byte_in,
   output hrfp_pkg::byte_type byte_out
);
   import hrfp_pkg::*;

   byte_type byte_ff;
   byte_type byte_in_next;

   // Take the neighbour's byte on a shift, hold otherwise
   always_comb begin
      byte_in_next = shift_en ? byte_in : byte_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_next;
   end

   assign byte_out = byte_ff;

endmodule

// ----- rtl/hid_report_frame_parser_unit.sv -----
// A word that completes a valid frame gives its report in the cycle after acceptance.
// Throughput: one input word per cycle; the output register lets a new word in
// while a pending report is taken, and only a stalled pending report holds req_ready low.
// Reset (synchronous, active high): parser idle, count and XOR cleared,
// registers back to their defaults, no report pending; payload cells are not cleared.
module hid_report_frame_parser_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input words
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic [7:0]                           req_data_byte,
   // Reports
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_report_kind,
   output logic [7:0]                           rsp_modifiers,
   output logic [47:0]                          rsp_key_codes,
   output logic [7:0]                           rsp_buttons,
   output logic signed [15:0]                   rsp_move_x,
   output logic signed [15:0]                   rsp_move_y,
   output logic signed [7:0]                    rsp_wheel,
   // Configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hrfp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hrfp_pkg::CSR_DATA_W-1:0]      csr_data
);
   import hrfp_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_DATA  = 2'd1,
      PH_CHECK = 2'd2
   } phase_type;

   // Configuration registers
   byte_type header_ff, keyboard_code_ff, mouse_code_ff;
   logic     keyboard_en_ff, mouse_en_ff;

   // Parser state
   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   byte_type             xor_ff, xor_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 kind_ff;
   byte_type             modifiers_ff, buttons_ff, wheel_ff;
   logic [47:0]          key_codes_ff;
   logic [15:0]          move_x_ff, move_y_ff;

   // Payload chain: byte 0 ends in cell 0 after a full frame
   byte_type             cell_q [PAYLOAD_LEN];
   logic                 shift_en;

   logic                 accept, feed, check_ok, keyboard_hit, mouse_hit, emit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign feed      = accept && (req_action == ACTION_FEED);
   assign shift_en  = feed && (phase_ff == PH_DATA);

   // Build the chain of payload cells
   for (genvar i = 0; i < PAYLOAD_LEN; i++) begin : g_cell
      byte_type cell_d;
      if (i == PAYLOAD_LEN - 1) begin : g_tail
         assign cell_d = req_data_byte;
      end else begin : g_link
         assign cell_d = cell_q[i+1];
      end
      hrfp_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .byte_in  (cell_d),
         .byte_out (cell_q[i])
      );
   end

   // Decode the report type from payload byte 1
   assign check_ok     = (phase_ff == PH_CHECK) && (req_data_byte == xor_ff);
   assign keyboard_hit = (cell_q[1] == keyboard_code_ff) && keyboard_en_ff;
   assign mouse_hit    = (cell_q[1] == mouse_code_ff) && mouse_en_ff;
   assign emit         = feed && check_ok && (keyboard_hit || mouse_hit);

   // Advance the frame state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      xor_in   = xor_ff;
      if (accept) begin
         if (req_action == ACTION_RESYNC) begin
            phase_in = PH_IDLE;
            count_in = '0;
            xor_in   = '0;
         end else begin
            unique case (phase_ff)
               PH_DATA: begin
                  count_in = count_ff + 1'b1;
                  xor_in   = xor_ff ^ req_data_byte;
                  if (count_in >= COUNT_W'(PAYLOAD_LEN)) begin
                     phase_in = PH_CHECK;
                  end
               end
               PH_CHECK: begin
                  phase_in = PH_IDLE;
                  count_in = '0;
                  xor_in   = '0;
               end
               default: begin
                  if (req_data_byte == header_ff) begin
                     phase_in = PH_DATA;
                     count_in = '0;
                     xor_in   = '0;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            endcase
         end
      end
   end

   // Drop the pending report once taken, load a new one on emit
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         xor_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold configuration, write on handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff        <= HEADER_RESET;
         keyboard_code_ff <= KEYBOARD_CODE_RESET;
         mouse_code_ff    <= MOUSE_CODE_RESET;
         keyboard_en_ff   <= 1'b1;
         mouse_en_ff      <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HEADER_BYTE:   header_ff        <= csr_data;
            CSR_KEYBOARD_CODE: keyboard_code_ff <= csr_data;
            CSR_MOUSE_CODE:    mouse_code_ff    <= csr_data;
            CSR_KEYBOARD_EN:   keyboard_en_ff   <= csr_data[0];
            CSR_MOUSE_EN:      mouse_en_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Load the report fields; keyboard wins when both codes match
   always_ff @(posedge clock) begin
      if (emit) begin
         if (keyboard_hit) begin
            kind_ff      <= KIND_KEYBOARD;
            modifiers_ff <= cell_q[0];
            key_codes_ff <= {cell_q[7], cell_q[6], cell_q[5],
                             cell_q[4], cell_q[3], cell_q[2]};
            buttons_ff   <= '0;
            move_x_ff    <= '0;
            move_y_ff    <= '0;
            wheel_ff     <= '0;
         end else begin
            kind_ff      <= KIND_MOUSE;
            modifiers_ff <= '0;
            key_codes_ff <= '0;
            buttons_ff   <= cell_q[2];
            move_x_ff    <= {cell_q[4], cell_q[3]};
            move_y_ff    <= {cell_q[6], cell_q[5]};
            wheel_ff     <= cell_q[7];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_report_kind = kind_ff;
   assign rsp_modifiers   = modifiers_ff;
   assign rsp_key_codes   = key_codes_ff;
   assign rsp_buttons     = buttons_ff;
   assign rsp_move_x      = signed'(move_x_ff);
   assign rsp_move_y      = signed'(move_y_ff);
   assign rsp_wheel       = signed'(wheel_ff);

endmodule

// ----- rtl/hrfp_checker.sv -----
// Port-level checks of the HID report frame parser, bound to the top level.
module hrfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_report_kind,
   input logic [7:0]  rsp_modifiers,
   input logic [47:0] rsp_key_codes,
   input logic [7:0]  rsp_buttons,
   input logic [15:0] rsp_move_x,
   input logic [15:0] rsp_move_y,
   input logic [7:0]  rsp_wheel
);

   // Clear any pending report on reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("report pending after reset");

   // Keep accepting input while no report waits
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");

   // Raise a report only after an accepted input word
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("report raised without an input word");

   // Zero the mouse fields of a keyboard report
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_report_kind) |->
         (rsp_buttons == 8'd0 && rsp_move_x == 16'd0 && rsp_move_y == 16'd0
          && rsp_wheel == 8'd0))
      else $error("keyboard report carries mouse fields");

   // Hold a stalled report valid, with its kind, modifiers, key codes and X movement unchanged
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_report_kind) && $stable(rsp_modifiers)
          && $stable(rsp_key_codes) && $stable(rsp_move_x)))
      else $error("stalled report changed");

endmodule

bind hid_report_frame_parser_unit hrfp_checker u_hrfp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_report_kind (rsp_report_kind),
   .rsp_modifiers   (rsp_modifiers),
   .rsp_key_codes   (rsp_key_codes),
   .rsp_buttons     (rsp_buttons),
   .rsp_move_x      (rsp_move_x),
   .rsp_move_y      (rsp_move_y),
   .rsp_wheel       (rsp_wheel)
);
